FILE: sv/ero3_pkg.sv
package ero3_pkg;

	localparam int MAX_WIDTH  = 640;
	localparam int PIX_W      = 16;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 11;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [COL_W-1:0] RESET_WIDTH  = 10'd640;
	localparam logic [ROW_W-1:0] RESET_HEIGHT = 11'd480;

	localparam int OPQ_DEPTH  = 4;
	localparam int OPQ_PTR_W  = $clog2(OPQ_DEPTH);
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);

	typedef struct packed {
		logic [COL_W-1:0] width;
		logic [ROW_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel;
		logic [ADDR_W-1:0] addr;
		logic              emit;
		logic              zero_val;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              last;
	} op_t;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} res_t;

	function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		return (b < a) ? b : a;
	endfunction

endpackage

FILE: sv/ero3_front.sv
module ero3_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ero3_pkg::cfg_t            cfg,
	input  logic                      push,
	output logic                      full,
	input  logic [ero3_pkg::PIX_W-1:0] pixel,
	output logic                      op_valid,
	output ero3_pkg::op_t             op,
	input  logic                      op_pop
);
	import ero3_pkg::*;

	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     eff_w;
	logic [ROW_W-1:0]     eff_h;
	logic                 line_end;
	logic                 frame_end;
	logic                 accept;
	op_t                  op_new;
	op_t                  opq_mem [OPQ_DEPTH];
	logic [OPQ_PTR_W-1:0] wr_ptr_q;
	logic [OPQ_PTR_W-1:0] rd_ptr_q;
	logic [OPQ_PTR_W:0]   cnt_q;
	logic                 deq;

	always_comb begin
		if (cfg.width < COL_W'(3)) begin
			eff_w = COL_W'(3);
		end else if (cfg.width > COL_W'(MAX_WIDTH)) begin
			eff_w = COL_W'(MAX_WIDTH);
		end else begin
			eff_w = cfg.width;
		end
		eff_h = (cfg.height < ROW_W'(3)) ? ROW_W'(3) : cfg.height;
	end

	assign line_end  = col_q >= (eff_w - COL_W'(1));
	assign frame_end = line_end && (row_q >= (eff_h - ROW_W'(1)));
	assign full      = cnt_q == (OPQ_PTR_W+1)'(OPQ_DEPTH);
	assign accept    = push && !full;
	assign op_valid  = cnt_q != '0;
	assign deq       = op_pop && op_valid;
	assign op        = opq_mem[rd_ptr_q];

	always_comb begin
		op_new.pixel    = pixel;
		op_new.addr     = col_q[ADDR_W-1:0];
		op_new.emit     = (row_q == '0) || ((row_q >= ROW_W'(2)) && (col_q != COL_W'(1)));
		op_new.zero_val = (row_q == '0) || (col_q == '0);
		op_new.row      = (row_q == '0) ? '0 : row_q - ROW_W'(1);
		op_new.col      = op_new.zero_val ? col_q : col_q - COL_W'(1);
		op_new.last     = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (line_end) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opq_mem[wr_ptr_q] <= op_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + OPQ_PTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + OPQ_PTR_W'(1);
			end
			case ({accept, deq})
				2'b10:   cnt_q <= cnt_q + (OPQ_PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (OPQ_PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < COL_W'(MAX_WIDTH))
		else $error("column counter beyond line buffer");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && frame_end) |=> (col_q == '0 && row_q == '0))
		else $error("counters not cleared at end of frame");

	a_opq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (OPQ_PTR_W+1)'(OPQ_DEPTH))
		else $error("op queue overflow");

endmodule

FILE: sv/ero3_back.sv
module ero3_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       op_valid,
	input  ero3_pkg::op_t              op,
	output logic                       op_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic [ero3_pkg::PIX_W-1:0] value,
	output logic [ero3_pkg::ROW_W-1:0] out_row,
	output logic [ero3_pkg::COL_W-1:0] out_col,
	output logic                       frame_last
);
	import ero3_pkg::*;

	logic [PIX_W-1:0]      older_mem [MAX_WIDTH];
	logic [PIX_W-1:0]      newer_mem [MAX_WIDTH];
	logic [PIX_W-1:0]      old_rd_s1;
	logic [PIX_W-1:0]      new_rd_s1;
	op_t                   op_s1;
	op_t                   op_s2;
	logic                  v_s1;
	logic                  v_s2;
	logic [PIX_W-1:0]      colmin_s2;
	logic [PIX_W-1:0]      h1_q;
	logic [PIX_W-1:0]      h2_q;
	logic [PIX_W-1:0]      win_min;
	logic                  issue;
	logic [RESQ_PTR_W:0]   pending;
	res_t                  res_new;
	res_t                  resq_mem [RESQ_DEPTH];
	logic [RESQ_PTR_W-1:0] wr_ptr_q;
	logic [RESQ_PTR_W-1:0] rd_ptr_q;
	logic [RESQ_PTR_W:0]   cnt_q;
	logic                  res_push;
	logic                  res_pop;
	res_t                  head;

	assign pending = cnt_q + (RESQ_PTR_W+1)'(v_s1) + (RESQ_PTR_W+1)'(v_s2);
	assign issue   = op_valid && (pending < (RESQ_PTR_W+1)'(RESQ_DEPTH));
	assign op_pop  = issue;

	always_ff @(posedge clk) begin
		if (issue) begin
			old_rd_s1 <= older_mem[op.addr];
			new_rd_s1 <= newer_mem[op.addr];
			op_s1     <= op;
		end
		if (v_s1) begin
			older_mem[op_s1.addr] <= new_rd_s1;
			newer_mem[op_s1.addr] <= op_s1.pixel;
			colmin_s2             <= min2(min2(old_rd_s1, new_rd_s1), op_s1.pixel);
			op_s2                 <= op_s1;
		end
		if (v_s2) begin
			h1_q <= colmin_s2;
			h2_q <= h1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	assign win_min  = min2(min2(colmin_s2, h1_q), h2_q);
	assign res_push = v_s2 && op_s2.emit;
	assign res_pop  = pop && !empty;

	always_comb begin
		res_new.value = op_s2.zero_val ? '0 : win_min;
		res_new.row   = op_s2.row;
		res_new.col   = op_s2.col;
		res_new.last  = op_s2.last;
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			resq_mem[wr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + RESQ_PTR_W'(1);
			end
			if (res_pop) begin
				rd_ptr_q <= rd_ptr_q + RESQ_PTR_W'(1);
			end
			case ({res_push, res_pop})
				2'b10:   cnt_q <= cnt_q + (RESQ_PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (RESQ_PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign empty      = cnt_q == '0;
	assign head       = resq_mem[rd_ptr_q];
	assign value      = head.value;
	assign out_row    = head.row;
	assign out_col    = head.col;
	assign frame_last = head.last;

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pending <= (RESQ_PTR_W+1)'(RESQ_DEPTH))
		else $error("results in flight exceed result queue room");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res_pop) |-> (cnt_q < (RESQ_PTR_W+1)'(RESQ_DEPTH)))
		else $error("result queue written while full");

	a_issue_valid: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> op_valid)
		else $error("op taken from empty queue");

endmodule

FILE: sv/erosion_3x3_min_filter_top.sv
// 3x3 grayscale erosion over a raster-order pixel stream.
// Input queue: drive pixel and push while full is low; one pixel a cycle.
// Result queue: while empty is low, value/out_row/out_col/frame_last show
// the oldest result; pop takes it. frame_last marks the frame's last result.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 width, 1 height) and
// cfg_data; cfg_ready is always high. Write only while the block is idle.
// Row 0 comes out as zeros, column 0 of later rows as zero; the other
// positions carry the minimum of their 3x3 neighborhood. The last column of
// interior rows and the whole last row give no result.
// Throughput: one item per cycle while the result queue has room, set by the
// single read/write port pair of the two line buffers, each read and written once per item.
// A taken item passes the line buffer read and column minimum registers; the window
// minimum is formed combinationally as the result is written to the output queue.
// A stalled receiver fills the 4-entry result queue, then the 4-entry op
// queue, and full rises; no item is lost.
// Reset clears the counters, both queues and sets width 640, height 480;
// line buffer contents stay undefined until written by the first two rows.
module erosion_3x3_min_filter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [ero3_pkg::PIX_W-1:0]      pixel,
	output logic                            empty,
	input  logic                            pop,
	output logic [ero3_pkg::PIX_W-1:0]      value,
	output logic [ero3_pkg::ROW_W-1:0]      out_row,
	output logic [ero3_pkg::COL_W-1:0]      out_col,
	output logic                            frame_last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ero3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ero3_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ero3_pkg::*;

	cfg_t cfg_q;
	logic op_valid;
	op_t  op;
	logic op_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= RESET_WIDTH;
			cfg_q.height <= RESET_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.width  <= cfg_data[COL_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.height <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	ero3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.full     (full),
		.pixel    (pixel),
		.op_valid (op_valid),
		.op       (op),
		.op_pop   (op_pop)
	);

	ero3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (op_valid),
		.op         (op),
		.op_pop     (op_pop),
		.empty      (empty),
		.pop        (pop),
		.value      (value),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_last (frame_last)
	);

endmodule

FILE: dv/erosion_3x3_min_filter_top_test.sv
`timescale 1ns / 100ps

module erosion_3x3_min_filter_top_test;
	import ero3_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int FINAL_CYCLES  = 48;
	localparam int RANDOM_PIXELS = 480;
	localparam int REPORT_MAX    = 10;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	logic [PIX_W-1:0]      pixel     = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	logic [PIX_W-1:0]      value;
	logic [ROW_W-1:0]      out_row;
	logic [COL_W-1:0]      out_col;
	logic                  frame_last;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic [COL_W-1:0] geo_width  = RESET_WIDTH;
	logic [ROW_W-1:0] geo_height = RESET_HEIGHT;
	logic [PIX_W-1:0] line_older [MAX_WIDTH];
	logic [PIX_W-1:0] line_newer [MAX_WIDTH];
	logic [PIX_W-1:0] nbhd [3][3];
	int unsigned      col_pos = 0;
	int unsigned      row_pos = 0;
	res_t             eroded_q [$];
	int               fail_cnt = 0;
	bit               steady_flow = 1'b0;

	erosion_3x3_min_filter_top dut (.*);

	always #1 clk = ~clk;

	function automatic void note_failure(input string msg);
		fail_cnt++;
		if (fail_cnt <= REPORT_MAX)
			$display("%s", msg);
	endfunction

	function automatic int pick_gap();
		int roll;
		if (steady_flow)
			return 0;
		roll = $urandom_range(99);
		if (roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		if (roll < 4)
			return PIX_W'($urandom_range(7));
		return PIX_W'($urandom);
	endfunction

	function automatic void predict_erosion(input logic [PIX_W-1:0] px);
		int unsigned      w, h, c, r;
		int               i, j;
		bit               line_end, frame_end;
		logic [PIX_W-1:0] m;
		res_t             res;
		w = int'(geo_width);
		if (w < 3)
			w = 3;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		h = int'(geo_height);
		if (h < 3)
			h = 3;
		c = col_pos;
		r = row_pos;
		line_end = (c >= w - 1);
		frame_end = line_end && (r >= h - 1);
		for (i = 0; i < 3; i++) begin
			nbhd[i][0] = nbhd[i][1];
			nbhd[i][1] = nbhd[i][2];
		end
		nbhd[0][2] = line_older[c];
		nbhd[1][2] = line_newer[c];
		nbhd[2][2] = px;
		line_older[c] = line_newer[c];
		line_newer[c] = px;
		res.last = frame_end;
		if (r == 0) begin
			res.value = '0;
			res.row = '0;
			res.col = COL_W'(c);
			eroded_q.push_back(res);
		end else if (r >= 2 && c != 1) begin
			res.value = '0;
			res.col = '0;
			if (c >= 2) begin
				m = nbhd[0][0];
				for (i = 0; i < 3; i++)
					for (j = 0; j < 3; j++)
						if (nbhd[i][j] < m)
							m = nbhd[i][j];
				res.value = m;
				res.col = COL_W'(c - 1);
			end
			res.row = ROW_W'(r - 1);
			eroded_q.push_back(res);
		end
		if (frame_end) begin
			col_pos = 0;
			row_pos = 0;
		end else if (line_end) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] px);
		int gap;
		bit took;
		gap = pick_gap();
		if (gap > 0) begin
			if (push) push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (!push) push <= 1'b1;
		pixel <= px;
		do begin
			@(negedge clk);
			took = !full;
			@(posedge clk);
		end while (!took);
		predict_erosion(px);
	endtask

	task automatic drain_results();
		if (push) push <= 1'b0;
		while (eroded_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_pixels(input int n, input int pause_at);
		for (int k = 0; k < n; k++) begin
			if (k == pause_at)
				drain_results();
			send_pixel(rand_pixel());
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data, input bit more);
		bit took;
		if (!cfg_valid) cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		if (idx == REG_FRAME_WIDTH)
			geo_width = data[COL_W-1:0];
		else
			geo_height = data[ROW_W-1:0];
		if (!more) cfg_valid <= 1'b0;
	endtask

	task automatic set_geometry(input logic [CFG_DATA_W-1:0] w_data,
			input logic [CFG_DATA_W-1:0] h_data);
		drain_results();
		write_reg(REG_FRAME_WIDTH, w_data, 1'b1);
		write_reg(REG_FRAME_HEIGHT, h_data, 1'b0);
	endtask

	task automatic test_reset_geometry();
		send_random_pixels(MAX_WIDTH, -1);
		set_geometry(11'd4, 11'd0);
		send_random_pixels(8, int'($urandom_range(1, 7)));
	endtask

	task automatic test_border_cases();
		logic [PIX_W-1:0] pattern [20] = '{
			16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h8000,
			16'h0001, 16'h7FFF, 16'hFFFE, 16'h1234, 16'hFEDC,
			16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0002, 16'hFFFF};
		set_geometry(11'd5, 11'd4);
		foreach (pattern[k])
			send_pixel(pattern[k]);
	endtask

	task automatic test_config_saturation();
		logic [CFG_DATA_W-1:0] w_list [5] = '{11'd0, 11'd1, 11'd2, 11'h403, 11'd3};
		logic [CFG_DATA_W-1:0] h_list [5] = '{11'd1, 11'd2, 11'd0, 11'd3, 11'd2};
		foreach (w_list[k]) begin
			set_geometry(w_list[k], h_list[k]);
			send_random_pixels(9, -1);
		end
	endtask

	task automatic test_tall_frame();
		set_geometry(11'd3, 11'd2047);
		send_random_pixels(120, -1);
		drain_results();
		write_reg(REG_FRAME_HEIGHT, 11'd1, 1'b0);
		send_random_pixels(3, -1);
	endtask

	task automatic test_random_frames();
		int sent, w, h, roll;
		sent = 0;
		w = 3;
		h = 3;
		while (sent < RANDOM_PIXELS) begin
			if (sent == 0 || $urandom_range(2) != 0) begin
				roll = $urandom_range(99);
				if (roll < 70)
					w = $urandom_range(3, 16);
				else if (roll < 92)
					w = $urandom_range(17, 64);
				else
					w = $urandom_range(65, 100);
				h = (w > 64) ? 3 : $urandom_range(3, 10);
				set_geometry(CFG_DATA_W'(w | ($urandom_range(1) << COL_W)),
					CFG_DATA_W'(h));
			end
			steady_flow = ($urandom_range(3) == 0);
			send_random_pixels(w * h,
				($urandom_range(4) == 0) ? $urandom_range(1, w * h - 1) : -1);
			sent += w * h;
		end
		steady_flow = 1'b0;
	endtask

	initial begin : stimulus
		foreach (line_older[i]) begin
			line_older[i] = '0;
			line_newer[i] = '0;
		end
		foreach (nbhd[i, j])
			nbhd[i][j] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_border_cases();
		test_config_saturation();
		test_tall_frame();
		test_random_frames();
		steady_flow = 1'b1;
		drain_results();
		repeat (FINAL_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : result_check
		int   stall;
		res_t want;
		stall = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			pop <= (stall == 0);
			if (stall > 0) stall--;
			@(negedge clk);
			if (pop && !empty) begin
				if (eroded_q.size() == 0) begin
					note_failure($sformatf("unexpected item: value %h row %0d col %0d last %b",
						value, out_row, out_col, frame_last));
				end else begin
					want = eroded_q.pop_front();
					if (value !== want.value || out_row !== want.row ||
							out_col !== want.col || frame_last !== want.last)
						note_failure($sformatf(
							"mismatch: expected %h r%0d c%0d last %b, got %h r%0d c%0d last %b",
							want.value, want.row, want.col, want.last,
							value, out_row, out_col, frame_last));
				end
				stall = pick_gap();
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule
